// ===== design/lph_pkg.sv =====
`default_nettype none

package lph_pkg;

    // Request codes.
    localparam logic [1:0] KIND_GET    = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_HAS    = 2'd2;
    localparam logic [1:0] KIND_REMOVE = 2'd3;

    // Hash finalizer constants.
    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int          MIX_S0 = 30;
    localparam int          MIX_S1 = 27;
    localparam int          MIX_S2 = 31;

    // One slot of the table as it sits in memory.
    typedef struct packed {
        logic        used;
        logic [63:0] key;
        logic [63:0] value;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/lph_store.sv =====
`default_nettype none

module lph_store
    import lph_pkg::*;
#(
    parameter int SLOTS  = 256,
    parameter int IDX_W  = 8
)
(
    input  wire logic             clk,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data
);

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/lph_hash.sv =====
`default_nettype none

module lph_hash
    import lph_pkg::*;
#(
    parameter int SLOTS = 256,
    parameter int IDX_W = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [63:0]      key,
    output logic                  done,
    output logic [IDX_W-1:0]      slot
);

    localparam logic [1:0] H_IDLE = 2'd0;
    localparam logic [1:0] H_MUL  = 2'd1;
    localparam logic [1:0] H_MOD  = 2'd2;
    localparam logic [1:0] H_FIX  = 2'd3;
    localparam bit IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
    // Floor of 2^64 / SLOTS; the quotient it yields is low by at most one.
    localparam logic [63:0] RECIP = 64'hFFFF_FFFF_FFFF_FFFF / 64'(SLOTS);
    localparam logic [IDX_W:0] MOD_S = (IDX_W+1)'(SLOTS);

    logic [1:0]       state_reg, state_next;
    logic             round_reg, round_next;
    logic [1:0]       sub_reg, sub_next;
    logic [63:0]      v_reg, v_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      prod_reg;
    logic [127:0]     wide_reg, wide_next;
    logic [IDX_W:0]   quot_reg, quot_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             done_reg, done_next;

    logic [31:0]      mul_a, mul_c;
    logic [63:0]      cst, sum, mixed;
    logic [127:0]     wide_add, wide_sum;
    logic [IDX_W:0]   back, trial;

    // One 32x32 multiplier builds the low half of each 64-bit product
    // from three partial products. For a slot count that is not a power of
    // two it also builds the high half of the hash times the reciprocal
    // from four partial products, which gives the quotient.
    always_comb
    begin
        cst   = (state_reg == H_MOD) ? RECIP : (round_reg ? MIX_C2 : MIX_C1);
        mul_a = sub_reg[1] ? v_reg[63:32] : v_reg[31:0];
        mul_c = sub_reg[0] ? cst[63:32] : cst[31:0];
        sum   = acc_reg + {prod_reg[31:0], 32'd0};
        mixed = round_reg ? (sum ^ (sum >> MIX_S2)) : (sum ^ (sum >> MIX_S1));
        priority if (state_reg == H_FIX)
        begin
            wide_add = {prod_reg, 64'd0};
        end
        else if (sub_reg == 2'd1)
        begin
            wide_add = {64'd0, prod_reg};
        end
        else
        begin
            wide_add = {32'd0, prod_reg, 32'd0};
        end
        wide_sum = wide_reg + wide_add;
        // Only the low bits of hash minus quotient times SLOTS are needed,
        // since the difference is below twice SLOTS.
        back  = (IDX_W+1)'(quot_reg * MOD_S);
        trial = v_reg[IDX_W:0] - back;
        if (trial >= MOD_S)
        begin
            trial = trial - MOD_S;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        sub_next   = sub_reg;
        v_next     = v_reg;
        acc_next   = acc_reg;
        wide_next  = wide_reg;
        quot_next  = quot_reg;
        slot_next  = slot_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    v_next     = key ^ (key >> MIX_S0);
                    round_next = 1'b0;
                    sub_next   = 2'd0;
                    state_next = H_MUL;
                end
            end
            H_MUL:
            begin
                sub_next = sub_reg + 2'd1;
                unique case (sub_reg)
                    2'd0: acc_next = acc_reg;
                    2'd1: acc_next = prod_reg;
                    2'd2: acc_next = sum;
                    default:
                    begin
                        v_next = mixed;
                        if (!round_reg)
                        begin
                            round_next = 1'b1;
                        end
                        else if (IS_POW2)
                        begin
                            slot_next  = mixed[IDX_W-1:0];
                            done_next  = 1'b1;
                            state_next = H_IDLE;
                        end
                        else
                        begin
                            wide_next  = '0;
                            state_next = H_MOD;
                        end
                    end
                endcase
            end
            H_MOD:
            begin
                sub_next = sub_reg + 2'd1;
                if (sub_reg != 2'd0)
                begin
                    wide_next = wide_sum;
                end
                if (sub_reg == 2'd3)
                begin
                    state_next = H_FIX;
                end
            end
            H_FIX:
            begin
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd0)
                begin
                    quot_next = wide_sum[64+IDX_W:64];
                end
                else
                begin
                    slot_next  = trial[IDX_W-1:0];
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        round_reg <= round_next;
        sub_reg   <= sub_next;
        v_reg     <= v_next;
        acc_reg   <= acc_next;
        wide_reg  <= wide_next;
        quot_reg  <= quot_next;
        slot_reg  <= slot_next;
        prod_reg  <= mul_a * mul_c;
    end

    assign done = done_reg;
    assign slot = slot_reg;

endmodule

`default_nettype wire

// ===== design/linear_probe_hash_table.sv =====
// Key/value store with 64-bit keys and values in SLOTS slots, open addressing
// with linear probing. A request (get, set, has key, remove) is taken when
// in_valid is high and in_stall low, and yields exactly one result beat on the
// out channel. After reset the block clears its memory with in_stall held
// high. A request first hashes its key; when SLOTS is not a power of two
// the hash is then reduced modulo SLOTS by a multiplication with its
// reciprocal. Each probed slot is then handled in S_ISSUE, which issues the read
// of the table memory, and in S_CHK, which checks the slot and writes it back.
// A remove also walks the cluster after the removed key and re-hashes and
// re-inserts every entry in it, so its time grows with cluster length.
// A request whose probe ends at its home slot offers its result beat from
// S_DONE, and in_stall is already low in the cycle that beat is first offered.
`default_nettype none

module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int SLOTS = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [63:0] lookup_key,
    input  wire logic [63:0] store_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             found,
    output logic [63:0]      read_value,
    output logic [8:0]       entry_count
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_ISSUE = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_WALK  = 3'd5;
    localparam logic [2:0] S_WCHK  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] start_reg, start_next;
    logic [IDX_W-1:0] walk_reg, walk_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       kind_reg, kind_next;
    logic [63:0]      pkey_reg, pkey_next;
    logic [63:0]      pval_reg, pval_next;
    logic             reins_reg, reins_next;
    logic             found_reg, found_next;
    logic [63:0]      rv_reg, rv_next;

    logic             out_valid_reg;
    logic             out_found_reg;
    logic [63:0]      out_value_reg;
    logic [8:0]       out_count_reg;

    logic             hash_start;
    logic [63:0]      hash_key;
    logic             hash_done;
    logic [IDX_W-1:0] hash_slot;

    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic             accept, load_out;
    logic             hit, probe_end;
    logic [1:0]       op;
    logic [IDX_W-1:0] pos_inc, walk_inc;
    logic [CNT_W+8:0] count_wide;

    lph_hash #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (hash_key),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    lph_store #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_store (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign pos_inc  = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
    assign walk_inc = (walk_reg == LAST) ? '0 : walk_reg + 1'b1;
    assign rd_addr  = (state_reg == S_WALK) ? walk_inc : pos_reg;

    // A probe ends on an empty slot, on the key, or after one full turn.
    assign hit       = rd_data.used && (rd_data.key == pkey_reg);
    assign probe_end = !rd_data.used || hit || (pos_inc == start_reg);
    assign op        = reins_reg ? KIND_SET : kind_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        walk_next  = walk_reg;
        steps_next = steps_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        pkey_next  = pkey_reg;
        pval_next  = pval_reg;
        reins_next = reins_reg;
        found_next = found_reg;
        rv_next    = rv_reg;
        hash_start = 1'b0;
        hash_key   = lookup_key;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = '{used: 1'b0, key: pkey_reg, value: pval_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = kind;
                    pkey_next  = lookup_key;
                    pval_next  = store_value;
                    reins_next = 1'b0;
                    found_next = 1'b0;
                    rv_next    = '0;
                    hash_start = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    pos_next   = hash_slot;
                    start_next = hash_slot;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!probe_end)
                begin
                    pos_next   = pos_inc;
                    state_next = S_ISSUE;
                end
                else
                begin
                    unique case (op)
                        KIND_GET:
                        begin
                            found_next = hit;
                            rv_next    = hit ? rd_data.value : 64'd0;
                            state_next = S_DONE;
                        end
                        KIND_HAS:
                        begin
                            found_next = hit;
                            state_next = S_DONE;
                        end
                        KIND_SET:
                        begin
                            // On a full table with the key absent the home
                            // slot is overwritten.
                            wr_en   = 1'b1;
                            wr_addr = (rd_data.used && !hit) ? start_reg : pos_reg;
                            wr_data = '{used: 1'b1, key: pkey_reg, value: pval_reg};
                            if (!rd_data.used)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            if (reins_reg)
                            begin
                                state_next = S_WALK;
                            end
                            else
                            begin
                                found_next = hit;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            if (hit)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg - 1'b1;
                                found_next = 1'b1;
                                walk_next  = pos_reg;
                                steps_next = '0;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (steps_reg == CNT_W'(SLOTS))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    walk_next  = walk_inc;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                if (!rd_data.used)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // Take the entry out and insert it again from its home.
                    wr_en      = 1'b1;
                    wr_addr    = walk_reg;
                    wr_data    = '{used: 1'b0, key: rd_data.key, value: rd_data.value};
                    count_next = count_reg - 1'b1;
                    pkey_next  = rd_data.key;
                    pval_next  = rd_data.value;
                    reins_next = 1'b1;
                    hash_key   = rd_data.key;
                    hash_start = 1'b1;
                    state_next = S_HASH;
                end
            end
            default:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign count_wide = {9'd0, count_reg};

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        start_reg <= start_next;
        walk_reg  <= walk_next;
        steps_reg <= steps_next;
        kind_reg  <= kind_next;
        pkey_reg  <= pkey_next;
        pval_reg  <= pval_next;
        reins_reg <= reins_next;
        found_reg <= found_next;
        rv_reg    <= rv_next;
        if (load_out)
        begin
            out_found_reg <= found_reg;
            out_value_reg <= rv_reg;
            out_count_reg <= count_wide[8:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign read_value  = out_value_reg;
    assign entry_count = out_count_reg;

    // The count of occupied slots never exceeds the table size.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("occupied count exceeds slot count");

    // An accepted request always starts with a hash of its key.
    a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_HASH))
        else $error("accepted request did not start hashing");

    // The hash unit only reports a slot while the controller waits for it.
    a_hash_done: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> (state_reg == S_HASH))
        else $error("hash result arrived outside the hash wait");

    // A new result beat is only raised from the completion state.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

endmodule

`default_nettype wire
